[sv/cbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared constants, character codes, the result type, hex helpers and a blank test.
// ----------------------------------------------------------------------------
package cbd_pkg;

	// Default width of the chunk size counter.
	localparam int CBD_SIZE_BITS = 32;

	// Character codes used on size lines and chunk trailers.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;

	// One result word, as produced for each accepted body byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       taken;
		logic       finished;
		logic       bad_size;
	} cbd_result_t;

	// True for an ASCII hex digit in either case.
	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
			(c >= "A" && c <= "F");
	endfunction

	// Value of a hex digit; only meaningful when is_hex is true.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= "0" && c <= "9") begin
			v = c - 8'("0");
		end else if (c >= "a" && c <= "f") begin
			v = c - 8'("a") + 8'd10;
		end else if (c >= "A" && c <= "F") begin
			v = c - 8'("A") + 8'd10;
		end
		return v[3:0];
	endfunction

	// Whitespace that is skipped before the first digit of a size.
	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF;
	endfunction

endpackage
`default_nettype wire

[sv/cbd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunked body decoder channels
// Valid/ready channels for the raw body bytes and for the decoded results.
// ----------------------------------------------------------------------------
interface cbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface cbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       taken;
	logic       finished;
	logic       bad_size;

	modport source (output valid, output data_byte, output data_valid, output taken,
		output finished, output bad_size, input ready);
	modport sink (input valid, input data_byte, input data_valid, input taken,
		input finished, input bad_size, output ready);
endinterface
`default_nettype wire

[sv/chunked_body_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// A word accepted on the body channel passes the input register, then the result register, to the output.
// The decode state machine takes one body word per cycle unless the output channel applies backpressure.
// The input register and the result register stall together only under output backpressure.
// Reset: arst_n clears the decode state to the start of a size line, zero count, no error,
// and empties both pipeline registers; payload registers are not reset.
// ----------------------------------------------------------------------------
// Chunked body decoder
// Decodes an HTTP chunked transfer body, one byte per word, into payload bytes.
// ----------------------------------------------------------------------------
module chunked_body_decoder import cbd_pkg::*; #(
	parameter int SIZE_BITS = CBD_SIZE_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	cbd_in_if.sink   body,
	cbd_out_if.source data
);

	// Input register: one body byte waits here for the decode step.
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Decode step result and the handshake with the result register.
	cbd_result_t result;
	logic        can_load;
	logic        advance;

	// The decode step runs when the input register holds a word and the
	// result register can take its result; the state machine advances only then,
	// so the order of words through the decoder is preserved.
	assign advance    = valid_s1 && can_load;
	assign body.ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.ready && body.valid) begin
			byte_s1 <= body.in_byte;
		end
	end

	// Size parsing, payload pass-through and trailer skipping.
	cbd_core #(
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.result  (result)
	);

	// Result register in front of the output channel.
	cbd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.result   (result),
		.can_load (can_load),
		.data     (data)
	);

endmodule
`default_nettype wire

[sv/cbd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunked body decoder core
// Decode state machine: one body byte per step, producing one result word.
// ----------------------------------------------------------------------------
module cbd_core import cbd_pkg::*; #(
	parameter int SIZE_BITS = CBD_SIZE_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  byte_in,
	output cbd_result_t      result
);

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_SIZE_CR,
		PH_DATA,
		PH_TRAIL,
		PH_TRAIL_CR,
		PH_DONE,
		PH_HALT
	} phase_t;

	phase_t               phase_q, phase_n;
	logic [SIZE_BITS-1:0] remaining_q, remaining_n;
	logic                 digit_seen_q, digit_seen_n;
	logic                 past_digits_q, past_digits_n;
	logic                 error_q, error_n;

	always_comb begin
		phase_n        = phase_q;
		remaining_n    = remaining_q;
		digit_seen_n   = digit_seen_q;
		past_digits_n  = past_digits_q;
		error_n        = error_q;
		result         = '0;
		result.taken   = 1'b1;
		case (phase_q)
			PH_SIZE: begin
				if (byte_in == CH_CR) begin
					phase_n = PH_SIZE_CR;
				end else if (!past_digits_q) begin
					if (is_hex(byte_in)) begin
						// A digit that would shift bits out of the counter is an overflow.
						if (remaining_q[SIZE_BITS-1 -: 4] != 4'h0) begin
							error_n = 1'b1;
							phase_n = PH_HALT;
						end else begin
							remaining_n  = {remaining_q[SIZE_BITS-5:0], hex_value(byte_in)};
							digit_seen_n = 1'b1;
						end
					end else if (!(is_blank(byte_in) && !digit_seen_q)) begin
						past_digits_n = 1'b1;
					end
				end
			end
			PH_SIZE_CR: begin
				if (byte_in == CH_LF) begin
					if (!digit_seen_q) begin
						error_n = 1'b1;
						phase_n = PH_HALT;
					end else if (remaining_q == '0) begin
						phase_n = PH_DONE;
					end else begin
						phase_n = PH_DATA;
					end
					digit_seen_n  = 1'b0;
					past_digits_n = 1'b0;
				end else if (byte_in == CH_CR) begin
					past_digits_n = 1'b1;
				end else begin
					past_digits_n = 1'b1;
					phase_n       = PH_SIZE;
				end
			end
			PH_DATA: begin
				result.data_byte  = byte_in;
				result.data_valid = 1'b1;
				remaining_n       = remaining_q - SIZE_BITS'(1);
				if (remaining_q == SIZE_BITS'(1)) begin
					phase_n = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				if (byte_in == CH_CR) begin
					phase_n = PH_TRAIL_CR;
				end
			end
			PH_TRAIL_CR: begin
				if (byte_in == CH_LF) begin
					phase_n     = PH_SIZE;
					remaining_n = '0;
				end else if (byte_in != CH_CR) begin
					phase_n = PH_TRAIL;
				end
			end
			default: begin
				result.taken = 1'b0;
			end
		endcase
		result.finished = (phase_n == PH_DONE);
		result.bad_size = error_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SIZE;
			remaining_q   <= '0;
			digit_seen_q  <= 1'b0;
			past_digits_q <= 1'b0;
			error_q       <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_n;
			remaining_q   <= remaining_n;
			digit_seen_q  <= digit_seen_n;
			past_digits_q <= past_digits_n;
			error_q       <= error_n;
		end
	end

	// The halt state is entered only together with the error flag.
	a_halt_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALT) |-> error_q)
		else $error("cbd_core: halted without a size error");

	// Finishing is final: once done, the decoder stays done.
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |=> (phase_q == PH_DONE))
		else $error("cbd_core: left the finished state");

	// Payload is only passed while a nonzero count remains.
	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (remaining_q != '0))
		else $error("cbd_core: payload phase with zero count");

	// A step in the payload phase always counts down by one.
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_DATA) |=> (remaining_q == $past(remaining_q) - SIZE_BITS'(1)))
		else $error("cbd_core: payload count did not decrement");

endmodule
`default_nettype wire

[sv/cbd_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Chunked body decoder result register
// Holds one result word and drives the output channel.
// ----------------------------------------------------------------------------
module cbd_out_stage import cbd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire cbd_result_t result,
	output logic             can_load,
	cbd_out_if.source        data
);

	logic        valid_s2;
	cbd_result_t result_s2;

	// The register may take a new word when empty or when its word leaves now.
	assign can_load = !valid_s2 || data.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			result_s2 <= result;
		end
	end

	assign data.valid      = valid_s2;
	assign data.data_byte  = result_s2.data_byte;
	assign data.data_valid = result_s2.data_valid;
	assign data.taken      = result_s2.taken;
	assign data.finished   = result_s2.finished;
	assign data.bad_size   = result_s2.bad_size;

endmodule
`default_nettype wire

[verif/chunked_body_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body decoder testbench
// Streams one chunked body through the decoder, predicts every result word
// from a bytewise model of the decode rules and checks each field in order.
// ----------------------------------------------------------------------------
module chunked_body_decoder_tb;
	import cbd_pkg::*;

	// Decode state of the predictor. It follows the same walk through a body
	// that the block takes: size line, its CR LF, payload, skipped trailer text,
	// and the two terminal states.
	typedef enum logic [2:0] {
		ST_LINE,
		ST_LINE_CR,
		ST_PAYLOAD,
		ST_TAIL,
		ST_TAIL_CR,
		ST_DONE,
		ST_HALTED
	} dec_state_t;

	logic clk;
	logic arst_n;

	cbd_in_if  body_ch ();
	cbd_out_if data_ch ();

	chunked_body_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body_ch),
		.data   (data_ch)
	);

	// Predictor state. The chunk count holds the size while a line is being
	// read and the payload bytes still owed once the line has ended.
	dec_state_t                 dec_state;
	logic [CBD_SIZE_BITS-1:0]   chunk_count;
	logic                       got_digit;
	logic                       digits_over;
	logic                       size_error;

	cbd_result_t expected_results[$];
	cbd_result_t oldest;
	int          fails;
	int          bytes_sent;

	// Percentages of cycles in which the body side holds back a word and the
	// result side refuses one.
	int src_idle_pct;
	int sink_stall_pct;

	logic [7:0] blank_set[5] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A hung handshake must still end the run with a verdict.
	initial begin
		#400000;
		$display("chunked_body_decoder regression: fail");
		$finish;
	end

	// The result side decides at every falling edge whether it takes a word.
	always @(negedge clk) begin
		data_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Advances the predictor by one body byte and returns the result word that
	// the block must produce for it.
	function automatic cbd_result_t decode_byte(input logic [7:0] c);
		cbd_result_t r;
		int          nib;
		r = '0;
		r.taken = 1'b1;
		nib = -1;
		if (c >= "0" && c <= "9") begin
			nib = c - "0";
		end else if (c >= "a" && c <= "f") begin
			nib = c - "a" + 10;
		end else if (c >= "A" && c <= "F") begin
			nib = c - "A" + 10;
		end
		case (dec_state)
			ST_LINE: begin
				if (c == CH_CR) begin
					dec_state = ST_LINE_CR;
				end else if (!digits_over) begin
					if (nib >= 0) begin
						// A digit that would shift a set bit out of the counter is
						// an error right away; the count never saturates.
						if (chunk_count[CBD_SIZE_BITS-1 -: 4] != 4'd0) begin
							size_error = 1'b1;
							dec_state = ST_HALTED;
						end else begin
							chunk_count = {chunk_count[CBD_SIZE_BITS-5:0], 4'(nib)};
							got_digit = 1'b1;
						end
					end else if (!((c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF}))
						|| got_digit) begin
						// Blanks are skipped only before the first digit; any
						// other text closes the digit run for this line.
						digits_over = 1'b1;
					end
				end
			end
			ST_LINE_CR: begin
				if (c == CH_LF) begin
					if (!got_digit) begin
						size_error = 1'b1;
						dec_state = ST_HALTED;
					end else if (chunk_count == '0) begin
						dec_state = ST_DONE;
					end else begin
						dec_state = ST_PAYLOAD;
					end
					got_digit = 1'b0;
					digits_over = 1'b0;
				end else if (c == CH_CR) begin
					digits_over = 1'b1;
				end else begin
					// A CR without LF is plain text on the size line.
					digits_over = 1'b1;
					dec_state = ST_LINE;
				end
			end
			ST_PAYLOAD: begin
				r.data_byte = c;
				r.data_valid = 1'b1;
				chunk_count = chunk_count - 1'b1;
				if (chunk_count == '0) begin
					dec_state = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (c == CH_CR) begin
					dec_state = ST_TAIL_CR;
				end
			end
			ST_TAIL_CR: begin
				if (c == CH_LF) begin
					dec_state = ST_LINE;
					chunk_count = '0;
				end else if (c != CH_CR) begin
					dec_state = ST_TAIL;
				end
			end
			default: begin
				r.taken = 1'b0;
			end
		endcase
		r.finished = (dec_state == ST_DONE);
		r.bad_size = size_error;
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		logic [7:0] c;
		c = (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
		if (upper && n >= 4'd10) begin
			c = c - 8'h20;
		end
		return c;
	endfunction

	// Any byte but CR, and optionally not LF either.
	function automatic logic [7:0] junk_byte(input bit no_lf);
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CH_CR || (no_lf && c == CH_LF));
		return c;
	endfunction

	// Offers one body word, after a random number of idle cycles, and records
	// its expected result once the decoder has taken it. Called and returns at
	// a falling edge; valid stays high so back-to-back words need no second
	// assignment in the same step.
	task automatic feed_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			body_ch.valid <= 1'b0;
			@(negedge clk);
		end
		body_ch.valid <= 1'b1;
		body_ch.in_byte <= b;
		@(posedge clk);
		while (!body_ch.ready) begin
			@(posedge clk);
		end
		expected_results.push_back(decode_byte(b));
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			feed_byte(s[i]);
		end
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
			default: begin src_idle_pct = 18; sink_stall_pct = 18; end
		endcase
	endtask

	// Short hand-written chunks around the size line and trailer rules: all
	// blanks before the digit (LF among them), a blank ending the digit run,
	// leading zero, an extension, a lone CR on the size line, CR CR LF at the
	// end of both a size line and a trailer, a lone CR in the trailer, and the
	// payload values at both ends of the byte range.
	task automatic test_directed_lines();
		set_idling(0);
		send_text("\t");
		feed_byte(CH_VT);
		feed_byte(CH_FF);
		send_text("\n 1 9\r\n");
		feed_byte(8'h00);
		send_text("\r\r\n");
		send_text("01;e\rq\r\r\n");
		feed_byte(8'hFF);
		send_text("z\rq\r\n");
	endtask

	// Well-formed chunks with random content make up most of the body, so the
	// decoder keeps cycling through all of its non-terminal states. The noise
	// sits where it cannot end decoding: extensions, lone CRs and junk after
	// the payload. The run walks through the idling modes in quarters.
	task automatic test_random_chunks();
		int unsigned size;
		int unsigned ndig;
		int unsigned zeros;
		while (bytes_sent < 900) begin
			set_idling((bytes_sent * 4) / 900);
			// Mostly short chunks, with the odd long one.
			size = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300)
				: $urandom_range(1, 24);
			ndig = 1;
			while ((size >> (4 * ndig)) != 0) begin
				ndig++;
			end
			if ($urandom_range(0, 7) == 0) begin
				zeros = 8 - ndig;
			end else if ($urandom_range(0, 3) == 0) begin
				zeros = $urandom_range(1, 3);
			end else begin
				zeros = 0;
			end

			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					feed_byte(blank_set[$urandom_range(0, 4)]);
				end
			end
			repeat (zeros) begin
				send_text("0");
			end
			for (int k = int'(ndig) - 1; k >= 0; k--) begin
				feed_byte(hex_char(4'((size >> (4 * k)) & 15), 1'($urandom_range(0, 1))));
			end
			// Text after the digits must start with a non-digit, or it would
			// simply extend the size.
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 2))
					0: send_text(";");
					1: send_text(" ");
					default: send_text("\t");
				endcase
				repeat ($urandom_range(0, 5)) begin
					feed_byte(junk_byte(1'b0));
				end
			end
			if ($urandom_range(0, 7) == 0) begin
				feed_byte(CH_CR);
				feed_byte(junk_byte(1'b1));
			end
			if ($urandom_range(0, 7) == 0) begin
				send_text("\r\r\n");
			end else begin
				send_text("\r\n");
			end

			repeat (size) begin
				feed_byte(8'($urandom_range(0, 255)));
			end

			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					feed_byte(junk_byte(1'b0));
				end
				if ($urandom_range(0, 1) == 0) begin
					feed_byte(CH_CR);
					feed_byte(junk_byte(1'b1));
				end
				if ($urandom_range(0, 1) == 0) begin
					feed_byte(CH_CR);
				end
			end
			send_text("\r\n");
		end
	endtask

	// Reset is applied only once, so a run can end its body only one way. The
	// seed picks the ending: a zero-size line, a zero read from a "0x" prefix,
	// a line of blanks only, text ahead of the digits, or a size one digit too
	// long. The bytes after it must all come back as not taken.
	task automatic test_halt_and_after();
		set_idling(3);
		case ($urandom_range(0, 4))
			0: send_text("0\r\n");
			1: send_text("0x1F\r\n");
			2: send_text(" \r\n");
			3: send_text("g1\r\n");
			default: begin
				feed_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
				repeat (8) begin
					feed_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
				end
				send_text("\r\n");
			end
		endcase
		send_text("5\r\nabcde\r\n");
		repeat (12) begin
			feed_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Each result word taken by the sink is held against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && data_ch.valid && data_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result word arrived with nothing expected");
				fails++;
			end else begin
				oldest = expected_results.pop_front();
				if (data_ch.data_byte !== oldest.data_byte) begin
					$error("data_byte: expected %02h, actual %02h",
						oldest.data_byte, data_ch.data_byte);
					fails++;
				end
				if (data_ch.data_valid !== oldest.data_valid) begin
					$error("data_valid: expected %0b, actual %0b",
						oldest.data_valid, data_ch.data_valid);
					fails++;
				end
				if (data_ch.taken !== oldest.taken) begin
					$error("taken: expected %0b, actual %0b", oldest.taken, data_ch.taken);
					fails++;
				end
				if (data_ch.finished !== oldest.finished) begin
					$error("finished: expected %0b, actual %0b",
						oldest.finished, data_ch.finished);
					fails++;
				end
				if (data_ch.bad_size !== oldest.bad_size) begin
					$error("bad_size: expected %0b, actual %0b",
						oldest.bad_size, data_ch.bad_size);
					fails++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		body_ch.valid = 1'b0;
		body_ch.in_byte = 8'h00;
		data_ch.ready = 1'b0;
		fails = 0;
		bytes_sent = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		dec_state = ST_LINE;
		chunk_count = '0;
		got_digit = 1'b0;
		digits_over = 1'b0;
		size_error = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_lines();
		test_random_chunks();
		test_halt_and_after();

		// Drain: stop offering words, let the sink take everything, then give
		// the two-stage pipeline time to show any stray word.
		body_ch.valid <= 1'b0;
		sink_stall_pct = 0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		if (fails == 0) begin
			$display("chunked_body_decoder regression: pass");
		end else begin
			$display("chunked_body_decoder regression: fail");
		end
		$finish;
	end

endmodule
